@@ hdl/tbps_pkg.sv @@
// Shared types and constants for the thread block panel swizzle.
// No dependencies; imported by tbps_udiv, thread_block_panel_swizzle and tb_top.
package tbps_pkg;

  // Grid coordinates and grid sizes are 16 bits wide.
  localparam int COORD_W     = 16;
  // Panel height register width and the largest usable panel height.
  localparam int PANEL_W     = 9;
  localparam int PANEL_MAX   = 256;
  // Offset inside a panel: below PANEL_MAX * 2**COORD_W.
  localparam int OFF_W       = COORD_W + PANEL_W - 1;
  // Default width of the launch coordinate ports.
  localparam int COORD_BITS_DEF = 16;

  localparam int CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLS  = 2'd0,
    CFG_GRID_ROWS  = 2'd1,
    CFG_PANEL_ROWS = 2'd2
  } cfg_idx_e;

  // Sideband carried through the first divider (panel index).
  typedef struct packed {
    logic               oog;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } div1_side_t;

  // Sideband carried through the second divider (column within panel).
  typedef struct packed {
    logic               oog;
    logic               odd;
    logic [COORD_W-1:0] base;
  } div2_side_t;

endpackage

@@ hdl/tbps_udiv.sv @@
// Two-stage pipelined unsigned restoring divider with a sideband payload.
// Depends on tbps_pkg for default widths.
module tbps_udiv #(
  parameter int QBITS  = tbps_pkg::COORD_W,
  parameter int DBITS  = tbps_pkg::PANEL_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic [DBITS-1:0]  rem_i,
  input  logic [QBITS-1:0]  num_i,
  input  logic [DBITS-1:0]  div_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [QBITS-1:0]  quo_o,
  output logic [DBITS-1:0]  rem_o,
  output logic [SIDE_W-1:0] side_o
);
  import tbps_pkg::*;

  localparam int STEPS_A = QBITS / 2;
  localparam int STEPS_B = QBITS - STEPS_A;

  logic              a_v_q, b_v_q;
  logic [DBITS-1:0]  a_rem_q, b_rem_q, a_div_q, b_div_q;
  logic [QBITS-1:0]  a_num_q, b_num_q;
  logic [SIDE_W-1:0] a_side_q, b_side_q;
  logic [DBITS-1:0]  a_rem_d, b_rem_d;
  logic [QBITS-1:0]  a_num_d, b_num_d;
  logic              a_en, b_en;

  assign b_en    = !b_v_q || !stall_i;
  assign a_en    = !a_v_q || b_en;
  assign stall_o = !a_en;

  // Shift dividend bits in at the bottom, quotient bits collect in their place.
  always_comb begin
    logic [DBITS:0] part;
    a_rem_d = rem_i;
    a_num_d = num_i;
    for (int i = 0; i < STEPS_A; i++) begin
      part    = {a_rem_d, a_num_d[QBITS-1]};
      a_num_d = {a_num_d[QBITS-2:0], 1'b0};
      if (part >= {1'b0, div_i}) begin
        part       = part - {1'b0, div_i};
        a_num_d[0] = 1'b1;
      end
      a_rem_d = part[DBITS-1:0];
    end
  end

  always_comb begin
    logic [DBITS:0] part;
    b_rem_d = a_rem_q;
    b_num_d = a_num_q;
    for (int i = 0; i < STEPS_B; i++) begin
      part    = {b_rem_d, b_num_d[QBITS-1]};
      b_num_d = {b_num_d[QBITS-2:0], 1'b0};
      if (part >= {1'b0, a_div_q}) begin
        part       = part - {1'b0, a_div_q};
        b_num_d[0] = 1'b1;
      end
      b_rem_d = part[DBITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      if (a_en) a_v_q <= valid_i;
      if (b_en) b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en) begin
      a_rem_q  <= a_rem_d;
      a_num_q  <= a_num_d;
      a_div_q  <= div_i;
      a_side_q <= side_i;
    end
    if (b_en) begin
      b_rem_q  <= b_rem_d;
      b_num_q  <= b_num_d;
      b_div_q  <= a_div_q;
      b_side_q <= a_side_q;
    end
  end

  assign valid_o = b_v_q;
  assign quo_o   = b_num_q;
  assign rem_o   = b_rem_q;
  assign side_o  = b_side_q;

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_v_q && (b_div_q != '0) && $past(a_rem_q < a_div_q) && $past(b_en)
      |-> b_rem_q < b_div_q)
    else $error("divider remainder not below divisor");

endmodule

@@ hdl/thread_block_panel_swizzle.sv @@
// Thread block panel swizzle: remaps launch coordinates into a serpentine panel order.
// Depends on tbps_pkg and tbps_udiv.
//
// The block takes one launch coordinate per cycle when not stalled and returns its
// remapped column and row, one result per item and no gaps. The depth comes from
// two pipelined restoring dividers, each two stages of eight quotient bits: the first
// finds the panel index (row over panel height), the second splits the offset within
// the panel into column and row (offset over stride). An input register, a stage that
// forms the offset and stride, and the output register make up the rest. Stalls
// collapse bubbles stage by stage, so a waiting result does not block new items while
// the pipeline has room. Coordinates outside the grid come out flagged with zeros.
// Write configuration only while no item is in flight; registers reset to one.
module thread_block_panel_swizzle #(
  parameter int COORD_BITS = tbps_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tbps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tbps_pkg::COORD_W-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [COORD_BITS-1:0]          launch_col_i,
  input  logic [COORD_BITS-1:0]          launch_row_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tbps_pkg::COORD_W-1:0]   mapped_col_o,
  output logic [tbps_pkg::COORD_W-1:0]   mapped_row_o,
  output logic                           out_of_grid_o
);
  import tbps_pkg::*;

  localparam int CMP_W = (COORD_BITS > COORD_W) ? COORD_BITS : COORD_W;
  localparam logic [COORD_W-1:0] OUT_MASK = (COORD_BITS >= COORD_W) ? {COORD_W{1'b1}} :
                                            COORD_W'((64'd1 << COORD_BITS) - 64'd1);

  // Configuration registers.
  logic [COORD_W-1:0] grid_cols_q, grid_rows_q;
  logic [PANEL_W-1:0] panel_rows_q, panel_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q  <= COORD_W'(1);
      grid_rows_q  <= COORD_W'(1);
      panel_rows_q <= PANEL_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GRID_COLS:  grid_cols_q  <= cfg_wdata_i;
        CFG_GRID_ROWS:  grid_rows_q  <= cfg_wdata_i;
        CFG_PANEL_ROWS: panel_rows_q <= cfg_wdata_i[PANEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp panel height to the usable range.
  always_comb begin
    if (panel_rows_q == '0)                        panel_eff = PANEL_W'(1);
    else if (panel_rows_q > PANEL_W'(PANEL_MAX))   panel_eff = PANEL_W'(PANEL_MAX);
    else                                           panel_eff = panel_rows_q;
  end

  // Stage 1: input register, grid test.
  logic                  s1_v_q, s1_en, d1_stall;
  logic [COORD_BITS-1:0] s1_col_q, s1_row_q;
  div1_side_t            d1_side_in, d1_side_out;

  assign s1_en      = !s1_v_q || !d1_stall;
  assign in_stall_o = !s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (s1_en) s1_v_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_col_q <= launch_col_i;
      s1_row_q <= launch_row_i;
    end
  end

  always_comb begin
    logic [CMP_W-1:0] col_x, row_x;
    col_x = CMP_W'(s1_col_q);
    row_x = CMP_W'(s1_row_q);
    d1_side_in.oog = (col_x >= CMP_W'(grid_cols_q)) || (row_x >= CMP_W'(grid_rows_q));
    d1_side_in.col = col_x[COORD_W-1:0];
    d1_side_in.row = row_x[COORD_W-1:0];
  end

  // Panel index and row within panel.
  logic               d1_valid, s4_stall_up;
  logic [COORD_W-1:0] d1_quo;
  logic [PANEL_W-1:0] d1_rem;

  tbps_udiv #(
    .QBITS (COORD_W),
    .DBITS (PANEL_W),
    .SIDE_W($bits(div1_side_t))
  ) u_div_panel (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s1_v_q),
    .stall_o(d1_stall),
    .rem_i  ('0),
    .num_i  (d1_side_in.row),
    .div_i  (panel_eff),
    .side_i (d1_side_in),
    .valid_o(d1_valid),
    .stall_i(s4_stall_up),
    .quo_o  (d1_quo),
    .rem_o  (d1_rem),
    .side_o (d1_side_out)
  );

  // Stage 4: panel base row, stride and offset within the panel.
  logic               s4_v_q, s4_en, d2_stall;
  logic [OFF_W-1:0]   s4_offset_q, s4_offset_d;
  logic [PANEL_W-1:0] s4_stride_q, s4_stride_d;
  div2_side_t         s4_side_q, s4_side_d;
  logic [COORD_W-1:0] base_row, rows_left;

  assign s4_en       = !s4_v_q || !d2_stall;
  assign s4_stall_up = !s4_en;

  always_comb begin
    base_row    = d1_side_out.row - COORD_W'(d1_rem);
    rows_left   = grid_rows_q - base_row;
    // Short last panel: the stride is the rows left.
    s4_stride_d = (rows_left < COORD_W'(panel_eff)) ? rows_left[PANEL_W-1:0] : panel_eff;
    s4_offset_d = OFF_W'(d1_rem * grid_cols_q) + OFF_W'(d1_side_out.col);
    s4_side_d.oog  = d1_side_out.oog;
    s4_side_d.odd  = d1_quo[0];
    s4_side_d.base = base_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else if (s4_en) s4_v_q <= d1_valid;
  end

  always_ff @(posedge clk_i) begin
    if (s4_en) begin
      s4_offset_q <= s4_offset_d;
      s4_stride_q <= s4_stride_d;
      s4_side_q   <= s4_side_d;
    end
  end

  // Column and row within the panel.
  logic               d2_valid, s7_stall_up;
  logic [COORD_W-1:0] d2_quo;
  logic [PANEL_W-1:0] d2_rem;
  div2_side_t         d2_side_out;

  tbps_udiv #(
    .QBITS (COORD_W),
    .DBITS (PANEL_W),
    .SIDE_W($bits(div2_side_t))
  ) u_div_offset (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s4_v_q),
    .stall_o(d2_stall),
    .rem_i  (PANEL_W'(s4_offset_q[OFF_W-1:COORD_W])),
    .num_i  (s4_offset_q[COORD_W-1:0]),
    .div_i  (s4_stride_q),
    .side_i (s4_side_q),
    .valid_o(d2_valid),
    .stall_i(s7_stall_up),
    .quo_o  (d2_quo),
    .rem_o  (d2_rem),
    .side_o (d2_side_out)
  );

  // Stage 7: serpentine column order, output register.
  logic               s7_v_q, s7_en, s7_oog_q;
  logic [COORD_W-1:0] s7_col_q, s7_row_q, col_d, row_d;

  assign s7_en       = !s7_v_q || !out_stall_i;
  assign s7_stall_up = !s7_en;

  always_comb begin
    if (d2_side_out.oog) begin
      col_d = '0;
      row_d = '0;
    end else begin
      // Odd panels run their columns right to left.
      col_d = d2_side_out.odd ? (grid_cols_q - COORD_W'(1) - d2_quo) : d2_quo;
      row_d = d2_side_out.base + COORD_W'(d2_rem);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s7_v_q <= 1'b0;
    else if (s7_en) s7_v_q <= d2_valid;
  end

  always_ff @(posedge clk_i) begin
    if (s7_en) begin
      s7_col_q <= col_d & OUT_MASK;
      s7_row_q <= row_d & OUT_MASK;
      s7_oog_q <= d2_side_out.oog;
    end
  end

  assign out_valid_o   = s7_v_q;
  assign mapped_col_o  = s7_col_q;
  assign mapped_row_o  = s7_row_q;
  assign out_of_grid_o = s7_oog_q;

  a_oog_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_grid_o |-> (mapped_col_o == '0) && (mapped_row_o == '0))
    else $error("out-of-grid item carries a nonzero mapping");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_v_q && d1_stall)
    else $error("input stalled while the first stage has room");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mapped_col_o) &&
      $stable(mapped_row_o) && $stable(out_of_grid_o))
    else $error("stalled result changed");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for thread_block_panel_swizzle: directed table, then random phases.
// Depends on tbps_pkg and the swizzle RTL; expected mappings come from the directed table or a local serpentine model.
module tb_top;
  import tbps_pkg::*;

  localparam int RESET_CYCLES    = 7;
  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int RAND_PHASES     = 14;
  localparam int PHASE_ITEMS     = 120;
  localparam int HOLD_PHASE      = 1;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int DIR_ROWS        = 36;

  typedef enum logic {ROW_REG_WRITE, ROW_LAUNCH} row_kind_e;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               oog;
  } swz_result_t;

  typedef struct packed {
    row_kind_e          kind;
    cfg_idx_e           idx;
    logic [COORD_W-1:0] wdata;
    logic [COORD_W-1:0] lc;
    logic [COORD_W-1:0] lr;
    logic               known;
    logic [COORD_W-1:0] k_col;
    logic [COORD_W-1:0] k_row;
    logic               k_oog;
  } dir_row_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [COORD_W-1:0] cfg_wdata_i   = '0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [COORD_W-1:0] launch_col_i  = '0;
  logic [COORD_W-1:0] launch_row_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [COORD_W-1:0] mapped_col_o;
  logic [COORD_W-1:0] mapped_row_o;
  logic               out_of_grid_o;

  // shadow of the block's registers, reset values
  logic [COORD_W-1:0] map_cols  = 1;
  logic [COORD_W-1:0] map_rows  = 1;
  logic [PANEL_W-1:0] map_panel = 1;

  swz_result_t expected_map_q[$];

  logic hold_off_req = 1'b0;
  logic quiet_tail   = 1'b0;
  int   error_count     = 0;
  int   items_sent      = 0;
  int   results_checked = 0;
  int   oog_checked     = 0;
  int   reg_writes      = 0;
  int   hold_offs       = 0;
  int   cycle_count     = 0;

  thread_block_panel_swizzle dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .launch_col_i (launch_col_i),
    .launch_row_i (launch_row_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .mapped_col_o (mapped_col_o),
    .mapped_row_o (mapped_row_o),
    .out_of_grid_o(out_of_grid_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Serpentine panel order: walk down stride rows per column, odd panels run right to left.
  function automatic swz_result_t swizzle_predict(logic [COORD_W-1:0] cx,
                                                  logic [COORD_W-1:0] cy);
    swz_result_t res;
    longint unsigned gc, gr, p, lin, span, pidx, offs, left, stride, col, row;
    res = '0;
    gc  = 64'(map_cols);
    gr  = 64'(map_rows);
    if (cx >= gc || cy >= gr) begin
      res.oog = 1'b1;
      return res;
    end
    if (map_panel == 0) p = 1;
    else if (map_panel > PANEL_MAX) p = PANEL_MAX;
    else p = 64'(map_panel);
    lin    = cx + cy * gc;
    span   = p * gc;
    pidx   = lin / span;
    offs   = lin % span;
    left   = gr - pidx * p;
    stride = (left < p) ? left : p;
    col    = offs / stride;
    if (pidx[0]) col = gc - 1 - col;
    row     = offs % stride + pidx * p;
    res.col = col[COORD_W-1:0];
    res.row = row[COORD_W-1:0];
    return res;
  endfunction

  function automatic logic [COORD_W-1:0] pick_axis(int unsigned extent, bit outside);
    if (outside || extent == 0) return COORD_W'($urandom_range(extent, (1 << COORD_W) - 1));
    if ($urandom_range(0, 7) == 0) return COORD_W'(extent - 1);
    return COORD_W'($urandom_range(0, extent - 1));
  endfunction

  function automatic logic [COORD_W-1:0] pick_extent();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return 1;
      2: return '1;
      3, 4: return COORD_W'($urandom);
      default: return COORD_W'($urandom_range(1, 24));
    endcase
  endfunction

  task automatic send_item(logic [COORD_W-1:0] c, logic [COORD_W-1:0] r, swz_result_t want);
    in_valid_i   <= 1'b1;
    launch_col_i <= c;
    launch_row_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_map_q = {expected_map_q, want};
    items_sent++;
  endtask

  task automatic idle_input(int n);
    in_valid_i   <= 1'b0;
    launch_col_i <= COORD_W'($urandom);
    launch_row_i <= COORD_W'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  // hold the input until every pending mapping is out, then let the pipe settle
  task automatic drain_input();
    in_valid_i <= 1'b0;
    while (expected_map_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [COORD_W-1:0] data);
    drain_input();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_GRID_COLS:  map_cols  = data;
      CFG_GRID_ROWS:  map_rows  = data;
      CFG_PANEL_ROWS: map_panel = data[PANEL_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  dir_row_t dir_table [DIR_ROWS] = '{
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       0,       0,       1, 0, 0, 0},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       1,       0,       1, 0, 0, 1},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       0,       1,       1, 0, 0, 1},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       'hFFFF,  'hFFFF,  1, 0, 0, 1},
    '{ROW_REG_WRITE, CFG_GRID_COLS,  5,       0,       0,       0, 0, 0, 0},
    '{ROW_REG_WRITE, CFG_GRID_ROWS,  7,       0,       0,       0, 0, 0, 0},
    '{ROW_REG_WRITE, CFG_PANEL_ROWS, 3,       0,       0,       0, 0, 0, 0},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       0,       0,       1, 0, 0, 0},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       4,       0,       0, 0, 0, 0},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       0,       3,       1, 4, 3, 0},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       4,       6,       1, 4, 6, 0},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       2,       5,       0, 0, 0, 0},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       4,       4,       0, 0, 0, 0},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       5,       0,       1, 0, 0, 1},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       0,       7,       1, 0, 0, 1},
    '{ROW_REG_WRITE, CFG_PANEL_ROWS, 0,       0,       0,       0, 0, 0, 0},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       3,       4,       0, 0, 0, 0},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       4,       1,       0, 0, 0, 0},
    '{ROW_REG_WRITE, CFG_PANEL_ROWS, 'hFFFF,  0,       0,       0, 0, 0, 0},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       3,       6,       0, 0, 0, 0},
    '{ROW_REG_WRITE, CFG_GRID_COLS,  0,       0,       0,       0, 0, 0, 0},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       0,       0,       1, 0, 0, 1},
    '{ROW_REG_WRITE, CFG_GRID_COLS,  'hFFFF,  0,       0,       0, 0, 0, 0},
    '{ROW_REG_WRITE, CFG_GRID_ROWS,  'hFFFF,  0,       0,       0, 0, 0, 0},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       'hFFFE,  'hFFFE,  0, 0, 0, 0},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       'hFFFF,  0,       1, 0, 0, 1},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       0,       0,       1, 0, 0, 0},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       0,       'hFFFF,  1, 0, 0, 1},
    '{ROW_REG_WRITE, CFG_GRID_ROWS,  0,       0,       0,       0, 0, 0, 0},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       0,       0,       1, 0, 0, 1},
    '{ROW_REG_WRITE, CFG_GRID_COLS,  1,       0,       0,       0, 0, 0, 0},
    '{ROW_REG_WRITE, CFG_GRID_ROWS,  'hFFFF,  0,       0,       0, 0, 0, 0},
    '{ROW_REG_WRITE, CFG_PANEL_ROWS, 256,     0,       0,       0, 0, 0, 0},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       0,       'hFFFE,  0, 0, 0, 0},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       0,       'hFFFF,  1, 0, 0, 1},
    '{ROW_LAUNCH,    CFG_GRID_COLS,  0,       0,       'hFF00,  0, 0, 0, 0}
  };

  initial begin : stimulus
    swz_result_t        want;
    logic [COORD_W-1:0] c, r, pv;
    int                 idle_odds, sel;
    bit                 gap_ok;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_REG_WRITE) begin
        write_reg(dir_table[i].idx, dir_table[i].wdata);
      end else begin
        if (dir_table[i].known)
          want = '{col: dir_table[i].k_col, row: dir_table[i].k_row, oog: dir_table[i].k_oog};
        else
          want = swizzle_predict(dir_table[i].lc, dir_table[i].lr);
        send_item(dir_table[i].lc, dir_table[i].lr, want);
        if ($urandom_range(0, 3) == 0) idle_input($urandom_range(1, 5));
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_reg(CFG_GRID_COLS, pick_extent());
      write_reg(CFG_GRID_ROWS, pick_extent());
      case ($urandom_range(0, 19))
        0: pv = 0;
        1: pv = COORD_W'(PANEL_MAX);
        2: pv = COORD_W'($urandom);
        3: pv = COORD_W'($urandom_range(PANEL_MAX + 1, (1 << PANEL_W) - 1));
        4: pv = 1;
        default: pv = COORD_W'($urandom_range(2, 12));
      endcase
      write_reg(CFG_PANEL_ROWS, pv);

      quiet_tail = (ph == RAND_PHASES - 1);
      case ($urandom_range(0, 2))
        0: idle_odds = 0;
        1: idle_odds = 3;
        default: idle_odds = 8;
      endcase
      if (quiet_tail) idle_odds = 0;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == HOLD_PHASE && k == 0) hold_off_req <= 1'b1;
        // mostly in-grid coordinates, some outside the grid on one axis, a few raw
        sel = $urandom_range(0, 99);
        c = pick_axis(map_cols, sel >= 80 && sel < 90);
        r = pick_axis(map_rows, sel >= 90 && sel < 96);
        if (sel >= 96) begin
          c = COORD_W'($urandom);
          r = COORD_W'($urandom);
        end
        send_item(c, r, swizzle_predict(c, r));
        // keep offering items back to back while the output is held off
        gap_ok = !(ph == HOLD_PHASE && k < 48);
        if (gap_ok && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
          idle_input($urandom_range(1, 5));
        else if (gap_ok && !quiet_tail && $urandom_range(0, 299) == 0)
          drain_input();
      end
    end

    in_valid_i <= 1'b0;
    while (expected_map_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("tb_top: %0d items sent, %0d results checked (%0d outside the grid)",
             items_sent, results_checked, oog_checked);
    $display("tb_top: %0d register writes over %0d random phases, %0d long output hold-off(s)",
             reg_writes, RAND_PHASES, hold_offs);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin : receiver
    int calm;
    calm = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        out_stall_i  <= 1'b0;
        hold_off_req <= 1'b0;
        hold_offs++;
      end else if (quiet_tail || !rst_ni) begin
        calm = 0;
      end else if (calm > 0) begin
        calm--;
      end else if ($urandom_range(0, 49) == 0) begin
        calm = $urandom_range(20, 80);
      end else if ($urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    swz_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_map_q.size() == 0) begin
        $error("unexpected result: mapped_col %0d mapped_row %0d out_of_grid %0b",
               mapped_col_o, mapped_row_o, out_of_grid_o);
        error_count++;
      end else begin
        want = expected_map_q.pop_front();
        results_checked++;
        if (want.oog) oog_checked++;
        if (mapped_col_o !== want.col) begin
          $error("mapped_col: expected %0d, actual %0d", want.col, mapped_col_o);
          error_count++;
        end
        if (mapped_row_o !== want.row) begin
          $error("mapped_row: expected %0d, actual %0d", want.row, mapped_row_o);
          error_count++;
        end
        if (out_of_grid_o !== want.oog) begin
          $error("out_of_grid: expected %0b, actual %0b", want.oog, out_of_grid_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

endmodule
